>>> hw/rtl/pftbp_pkg.sv
// ----------------------------------------------------------------------------
// pftbp_pkg
// Shared types, constants and helpers of the per-flow token bucket policer.
// ----------------------------------------------------------------------------
package pftbp_pkg;

    // Defaults of the top-level parameters
    localparam int unsigned NUM_FLOWS_DEF  = 256;
    localparam int unsigned TOKEN_BITS_DEF = 16;
    localparam int unsigned TIME_BITS_DEF  = 32;

    // Fixed field widths
    localparam int unsigned FLOW_ID_W  = 8;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned LEFT_W     = 16;

    // Stream payload widths (whole bytes)
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAP_FREE    = 2'd0,
        CFG_REFILL_FREE = 2'd1,
        CFG_CAP_PREM    = 2'd2,
        CFG_REFILL_PREM = 2'd3
    } t_cfg_reg;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] CAP_FREE_RST    = 16'd5;
    localparam logic [CFG_W-1:0] REFILL_FREE_RST = 16'd1;
    localparam logic [CFG_W-1:0] CAP_PREM_RST    = 16'd10;
    localparam logic [CFG_W-1:0] REFILL_PREM_RST = 16'd5;

    // Bucket settings of one tier
    typedef struct packed {
        logic [CFG_W-1:0] capacity;
        logic [CFG_W-1:0] refill;
    } t_tier_cfg;

    // Flow id folded into the table range: restoring reduction, one
    // conditional subtract per id bit
    function automatic logic [15:0] flow_index(input logic [FLOW_ID_W-1:0] id,
                                               input int unsigned num);
        int unsigned v;
        int unsigned step;
        v = 32'(id);
        for (int k = FLOW_ID_W - 1; k >= 0; k--) begin
            step = num << k;
            if (v >= step) begin
                v = v - step;
            end
        end
        return v[15:0];
    endfunction

endpackage

>>> hw/rtl/pftbp_flow_mem.sv
// ----------------------------------------------------------------------------
// pftbp_flow_mem
// Per-flow state memory: one write port, one registered read port, write to
// read forwarding for back-to-back hits, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pftbp_flow_mem
    import pftbp_pkg::*;
#(
    parameter int unsigned NUM_FLOWS = NUM_FLOWS_DEF,
    parameter int unsigned WORD_W    = 49
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(NUM_FLOWS)-1:0] i_rd_addr,
    output logic [WORD_W-1:0]            o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(NUM_FLOWS)-1:0] i_wr_addr,
    input  logic [WORD_W-1:0]            i_wr_data,
    output logic                         o_busy
);

    localparam int unsigned IDX_W = $clog2(NUM_FLOWS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FLOWS - 1);

    logic [WORD_W-1:0] r_mem [NUM_FLOWS];
    logic [WORD_W-1:0] r_rd_q;
    logic [WORD_W-1:0] r_fwd_data;
    logic              r_fwd_hit;
    logic              r_clr_busy;
    logic [IDX_W-1:0]  r_clr_cnt;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    // Clearing sweep owns the write port until every entry is invalid
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_cnt;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    // Sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Read port; same-edge write to the read address is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q     <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_q;
    assign o_busy    = r_clr_busy;

endmodule

>>> hw/rtl/pftbp_bucket.sv
// ----------------------------------------------------------------------------
// pftbp_bucket
// Refill, saturation and token take for one request.
// ----------------------------------------------------------------------------
module pftbp_bucket
    import pftbp_pkg::*;
#(
    parameter int unsigned TOKEN_BITS = TOKEN_BITS_DEF,
    parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
    input  t_tier_cfg             i_cfg,
    input  logic                  i_valid,
    input  logic [TOKEN_BITS-1:0] i_tokens,
    input  logic [TIME_BITS-1:0]  i_last,
    input  logic [TIME_BITS-1:0]  i_now,
    output logic                  o_allowed,
    output logic [TOKEN_BITS-1:0] o_tokens
);

    localparam logic [32:0] TOKEN_MAX = (33'd1 << TOKEN_BITS) - 33'd1;

    logic [32:0]           cap_w;
    logic [TOKEN_BITS-1:0] tokens_in;
    logic [TIME_BITS-1:0]  last_in;
    logic [TIME_BITS-1:0]  elapsed;
    logic [63:0]           elapsed_w;
    logic                  elapsed_big;
    logic [47:0]           prod;
    logic [48:0]           add;
    logic [49:0]           sum;
    logic [32:0]           sat;
    logic [32:0]           left;

    // Capacity clamped to the token range
    always_comb begin
        if (33'(i_cfg.capacity) > TOKEN_MAX) begin
            cap_w = TOKEN_MAX;
        end else begin
            cap_w = 33'(i_cfg.capacity);
        end
    end

    // New flow starts full with no elapsed time
    assign tokens_in = i_valid ? i_tokens : cap_w[TOKEN_BITS-1:0];
    assign last_in   = i_valid ? i_last : i_now;

    // Elapsed seconds, zero when time went backwards
    assign elapsed     = (i_now > last_in) ? (i_now - last_in) : '0;
    assign elapsed_w   = 64'(elapsed);
    assign elapsed_big = |elapsed_w[63:32];
    assign prod        = 48'(elapsed_w[31:0]) * 48'(i_cfg.refill);

    // Refill amount
    always_comb begin
        if (i_cfg.refill == '0) begin
            add = '0;
        end else if (elapsed_big) begin
            add = 49'(cap_w);
        end else begin
            add = 49'(prod);
        end
    end

    // Saturate at capacity, then take one token if any
    assign sum       = 50'(tokens_in) + 50'(add);
    assign sat       = (sum > 50'(cap_w)) ? cap_w : sum[32:0];
    assign o_allowed = (sat != '0);
    assign left      = o_allowed ? (sat - 33'd1) : '0;
    assign o_tokens  = left[TOKEN_BITS-1:0];

endmodule

>>> hw/rtl/per_flow_token_bucket_policer.sv
// ----------------------------------------------------------------------------
// per_flow_token_bucket_policer
// Path: stage 1 request, then output register. Throughput: 1 item per cycle
// while the output is not back-pressured; flow state sits in a memory with a
// registered read port, a repeated flow in consecutive cycles is served by
// forwarding. Reset: synchronous, active low; afterwards a clearing sweep of
// NUM_FLOWS entries invalidates every flow, during which no item is accepted.
// ----------------------------------------------------------------------------
module per_flow_token_bucket_policer
    import pftbp_pkg::*;
#(
    parameter int unsigned NUM_FLOWS  = NUM_FLOWS_DEF,
    parameter int unsigned TOKEN_BITS = TOKEN_BITS_DEF,
    parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // flow_id[7:0], now[39:8]
    input  logic                  i_s_tuser,   // tier
    // decision stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata    // allowed[0], tokens_left[16:1],
                                               // retry_after[17], zero[23:18]
);

    localparam int unsigned IDX_W   = $clog2(NUM_FLOWS);
    localparam int unsigned ENTRY_W = 1 + TIME_BITS + TOKEN_BITS;

    // Configuration registers
    logic [CFG_W-1:0] r_cap_free;
    logic [CFG_W-1:0] r_refill_free;
    logic [CFG_W-1:0] r_cap_prem;
    logic [CFG_W-1:0] r_refill_prem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_free    <= CAP_FREE_RST;
            r_refill_free <= REFILL_FREE_RST;
            r_cap_prem    <= CAP_PREM_RST;
            r_refill_prem <= REFILL_PREM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_CAP_FREE:    r_cap_free    <= i_cfg_wdata;
                CFG_REFILL_FREE: r_refill_free <= i_cfg_wdata;
                CFG_CAP_PREM:    r_cap_prem    <= i_cfg_wdata;
                CFG_REFILL_PREM: r_refill_prem <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake and stage control
    logic                 accept;
    logic                 s1_adv;
    logic                 mem_busy;
    logic                 r_s1_vld;
    logic [IDX_W-1:0]     r_s1_idx;
    logic                 r_s1_tier;
    logic [TIME_BITS-1:0] r_s1_now;
    logic                 r_out_vld;
    logic                 r_out_allowed;
    logic [LEFT_W-1:0]    r_out_left;

    logic [15:0]          idx_full;
    logic [IDX_W-1:0]     in_idx;
    logic [TIME_BITS-1:0] in_now;

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !mem_busy && (!r_s1_vld || s1_adv);
    assign accept     = i_s_tvalid && o_s_tready;

    // Input decode
    assign idx_full = flow_index(i_s_tdata[FLOW_ID_W-1:0], NUM_FLOWS);
    assign in_idx   = idx_full[IDX_W-1:0];
    assign in_now   = TIME_BITS'(i_s_tdata[FLOW_ID_W +: NOW_W]);

    // Stage 1 request register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx  <= in_idx;
            r_s1_tier <= i_s_tuser;
            r_s1_now  <= in_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Flow state memory
    logic [ENTRY_W-1:0]    rd_entry;
    logic [ENTRY_W-1:0]    wr_entry;
    logic                  calc_allowed;
    logic [TOKEN_BITS-1:0] calc_tokens;
    t_tier_cfg             tier_cfg;

    pftbp_flow_mem #(
        .NUM_FLOWS (NUM_FLOWS),
        .WORD_W    (ENTRY_W)
    ) u_flow_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (in_idx),
        .o_rd_data (rd_entry),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (wr_entry),
        .o_busy    (mem_busy)
    );

    // Tier settings
    always_comb begin
        if (r_s1_tier) begin
            tier_cfg.capacity = r_cap_prem;
            tier_cfg.refill   = r_refill_prem;
        end else begin
            tier_cfg.capacity = r_cap_free;
            tier_cfg.refill   = r_refill_free;
        end
    end

    // Entry layout: tokens low, last refill time, valid on top
    pftbp_bucket #(
        .TOKEN_BITS (TOKEN_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_bucket (
        .i_cfg     (tier_cfg),
        .i_valid   (rd_entry[ENTRY_W-1]),
        .i_tokens  (rd_entry[TOKEN_BITS-1:0]),
        .i_last    (rd_entry[TOKEN_BITS +: TIME_BITS]),
        .i_now     (r_s1_now),
        .o_allowed (calc_allowed),
        .o_tokens  (calc_tokens)
    );

    assign wr_entry = {1'b1, r_s1_now, calc_tokens};

    // Result register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_allowed <= calc_allowed;
            r_out_left    <= LEFT_W'(calc_tokens);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, !r_out_allowed, r_out_left, r_out_allowed};

endmodule
